/* hdl/fbsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsc_pkg
// Shared types, register codes and helpers of the frustum cull chain.
// ----------------------------------------------------------------------------
package fbsc_pkg;

    localparam int PLANE_REGS = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int Q14_SHIFT  = 14;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TOP    = 3'd0,
        REG_BOTTOM = 3'd1,
        REG_RIGHT  = 3'd2,
        REG_LEFT   = 3'd3,
        REG_NEAR   = 3'd4,
        REG_FAR    = 3'd5,
        REG_ENABLE = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] size_x;
        logic signed [15:0] size_y;
        logic signed [15:0] size_z;
        logic [14:0]        radius;
        logic               visible;
        logic               contained;
    } item_t;

    typedef struct packed {
        logic                  plane_we;
        logic                  en_we;
        logic                  en_bit;
        logic [CFG_DATA_W-1:0] data;
    } cell_cfg_t;

    // sphere: centre coordinate; box: twice the centre
    function automatic logic signed [17:0] axis_operand(
        input logic               mode,
        input logic signed [15:0] pos,
        input logic signed [15:0] size
    );
        logic signed [17:0] twice;
        twice = 18'(pos) <<< 1;
        return mode ? 18'(pos) : twice + 18'(size);
    endfunction

    function automatic logic [15:0] mag16(input logic [15:0] v);
        return v[15] ? (~v + 16'd1) : v;
    endfunction

endpackage

/* hdl/fbsc_obj_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsc_obj_if
// Object channel: one bounding volume per beat.
// ----------------------------------------------------------------------------
interface fbsc_obj_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [15:0] size_x;
    logic signed [15:0] size_y;
    logic signed [15:0] size_z;
    logic [14:0]        radius;

    modport source (
        output valid, mode, pos_x, pos_y, pos_z, size_x, size_y, size_z, radius,
        input  ready
    );
    modport sink (
        input  valid, mode, pos_x, pos_y, pos_z, size_x, size_y, size_z, radius,
        output ready
    );
endinterface

/* hdl/fbsc_res_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsc_res_if
// Result channel: one cull verdict per beat.
// ----------------------------------------------------------------------------
interface fbsc_res_if;
    logic valid;
    logic ready;
    logic visible;
    logic fully_inside;

    modport source (
        output valid, visible, fully_inside,
        input  ready
    );
    modport sink (
        input  valid, visible, fully_inside,
        output ready
    );
endinterface

/* hdl/fbsc_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsc_cell
// One plane of the chain: holds the plane and its enable, forms the
// products in a first stage and the distance test in a second stage.
// ----------------------------------------------------------------------------
module fbsc_cell
    import fbsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cell_cfg_t cfg,
    input  logic      in_valid,
    output logic      in_ready,
    input  item_t     in_item,
    output logic      out_valid,
    input  logic      out_ready,
    output item_t     out_item
);

    logic [CFG_DATA_W-1:0] plane_reg;
    logic                  en_reg;

    logic                  s1_valid_reg, s1_valid_next;
    item_t                 s1_item_reg;
    logic signed [33:0]    s1_prod_x_reg, s1_prod_y_reg, s1_prod_z_reg;
    logic [30:0]           s1_push_x_reg, s1_push_y_reg, s1_push_z_reg;

    logic                  s2_valid_reg, s2_valid_next;
    item_t                 s2_item_reg, s2_item_next;

    logic                  s1_ready, s2_ready;
    logic signed [15:0]    nx, ny, nz, off;
    logic signed [17:0]    ax, ay, az;
    logic signed [33:0]    prod_x_next, prod_y_next, prod_z_next;
    logic [30:0]           push_x_next, push_y_next, push_z_next;
    logic signed [37:0]    off_term, plane_dist, bound, neg_bound;

    assign nx  = plane_reg[15:0];
    assign ny  = plane_reg[31:16];
    assign nz  = plane_reg[47:32];
    assign off = plane_reg[63:48];

    assign s2_ready = !s2_valid_reg || out_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_comb
    begin
        ax = axis_operand(in_item.mode, in_item.pos_x, in_item.size_x);
        ay = axis_operand(in_item.mode, in_item.pos_y, in_item.size_y);
        az = axis_operand(in_item.mode, in_item.pos_z, in_item.size_z);
        prod_x_next = 34'(ax) * 34'(nx);
        prod_y_next = 34'(ay) * 34'(ny);
        prod_z_next = 34'(az) * 34'(nz);
        push_x_next = 31'(mag16(in_item.size_x)) * 31'(mag16(nx));
        push_y_next = 31'(mag16(in_item.size_y)) * 31'(mag16(ny));
        push_z_next = 31'(mag16(in_item.size_z)) * 31'(mag16(nz));
    end

    always_comb
    begin
        off_term = s1_item_reg.mode ? (38'(off) <<< Q14_SHIFT)
                                    : (38'(off) <<< (Q14_SHIFT + 1));
        plane_dist = 38'(s1_prod_x_reg) + 38'(s1_prod_y_reg) + 38'(s1_prod_z_reg)
                   - off_term;
        bound    = s1_item_reg.mode ? 38'({s1_item_reg.radius, 14'd0})
                                    : 38'(s1_push_x_reg) + 38'(s1_push_y_reg)
                                      + 38'(s1_push_z_reg);
        neg_bound = -bound;
        s2_item_next = s1_item_reg;
        if (en_reg && (plane_dist > bound))
        begin
            s2_item_next.visible = 1'b0;
        end
        if (en_reg && (plane_dist > neg_bound))
        begin
            s2_item_next.contained = 1'b0;
        end
    end

    assign s1_valid_next = s1_ready ? in_valid : s1_valid_reg;
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg    <= '0;
            en_reg       <= 1'b1;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.plane_we)
            begin
                plane_reg <= cfg.data;
            end
            if (cfg.en_we)
            begin
                en_reg <= cfg.en_bit;
            end
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_item_reg   <= in_item;
            s1_prod_x_reg <= prod_x_next;
            s1_prod_y_reg <= prod_y_next;
            s1_prod_z_reg <= prod_z_next;
            s1_push_x_reg <= push_x_next;
            s1_push_y_reg <= push_y_next;
            s1_push_z_reg <= push_z_next;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

/* hdl/frustum_box_sphere_cull_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_box_sphere_cull_unit
// Culls boxes and spheres against up to six configurable frustum planes.
// ----------------------------------------------------------------------------
// obj carries one bounding volume per beat (mode 0 box: corner and extent,
// mode 1 sphere: centre and radius); result carries visible and
// fully_inside per beat, in order. The cfg_wr_* port writes the six plane
// registers (index 0..5) and the enable mask (index 6). The user must write
// them only while the unit is idle; the unit itself does not enforce this.
// Each plane is a cell of two register stages, followed by one output
// register. One object is taken every cycle while the result sink does not
// stall; the rate is set by the cell chain, which moves one item per stage
// per cycle.
// A stalled result sink holds the output register; the stages upstream keep
// filling their empty slots, and obj.ready drops only once the chain is full.
// Reset empties the chain, clears the planes and enables all of them.
// ----------------------------------------------------------------------------
module frustum_box_sphere_cull_unit
    import fbsc_pkg::*;
#(
    parameter int NUM_PLANES = 6
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    fbsc_obj_if.sink              obj,
    fbsc_res_if.source            result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    localparam int NC = (NUM_PLANES < PLANE_REGS) ? NUM_PLANES : PLANE_REGS;

    logic  chain_valid [NC+1];
    logic  chain_ready [NC+1];
    item_t chain_item  [NC+1];

    logic  out_valid_reg, out_valid_next;
    logic  out_visible_reg;
    logic  out_inside_reg;
    logic  out_free;

    always_comb
    begin
        chain_item[0].mode      = obj.mode;
        chain_item[0].pos_x     = obj.pos_x;
        chain_item[0].pos_y     = obj.pos_y;
        chain_item[0].pos_z     = obj.pos_z;
        chain_item[0].size_x    = obj.size_x;
        chain_item[0].size_y    = obj.size_y;
        chain_item[0].size_z    = obj.size_z;
        chain_item[0].radius    = obj.radius;
        chain_item[0].visible   = 1'b1;
        chain_item[0].contained = 1'b1;
    end

    assign chain_valid[0] = obj.valid;
    assign obj.ready      = chain_ready[0];

    generate
        for (genvar i = 0; i < NC; i++)
        begin : g_cell
            cell_cfg_t cell_cfg;

            always_comb
            begin
                cell_cfg.plane_we = cfg_wr_en && (cfg_index == CFG_IDX_W'(i));
                cell_cfg.en_we    = cfg_wr_en && (cfg_index == REG_ENABLE);
                cell_cfg.en_bit   = cfg_wr_data[i];
                cell_cfg.data     = cfg_wr_data;
            end

            fbsc_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cfg       (cell_cfg),
                .in_valid  (chain_valid[i]),
                .in_ready  (chain_ready[i]),
                .in_item   (chain_item[i]),
                .out_valid (chain_valid[i+1]),
                .out_ready (chain_ready[i+1]),
                .out_item  (chain_item[i+1])
            );
        end
    endgenerate

    assign out_free       = !out_valid_reg || result.ready;
    assign chain_ready[NC] = out_free;
    assign out_valid_next = out_free ? chain_valid[NC] : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && chain_valid[NC])
        begin
            out_visible_reg <= chain_item[NC].visible;
            out_inside_reg  <= chain_item[NC].mode && chain_item[NC].visible
                               && chain_item[NC].contained;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.visible      = out_visible_reg;
    assign result.fully_inside = out_inside_reg;

endmodule

/* hdl/fbsc_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsc_checker
// Port-level checks of the frustum cull unit, bound to the top level.
// ----------------------------------------------------------------------------
module fbsc_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic visible,
    input logic fully_inside
);

    a_reset_empty: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result beat during reset");

    a_inside_visible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (visible || !fully_inside))
        else $error("fully_inside without visible");

    a_free_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready)
        else $error("object beat refused with free output");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(visible) && $stable(fully_inside)))
        else $error("stalled result beat changed");

    a_ready_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_ready))
        else $error("object ready unknown on a valid beat");

endmodule

bind frustum_box_sphere_cull_unit fbsc_checker u_fbsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (obj.valid),
    .in_ready     (obj.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .visible      (result.visible),
    .fully_inside (result.fully_inside)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frustum box and sphere cull unit.
// ----------------------------------------------------------------------------
// Objects are queued by the stimulus process and sent by a clocked driver.
// A clocked monitor keeps its own copy of the planes and the enable mask,
// predicts the verdict of every object beat it sees accepted, and compares
// each result beat with the oldest prediction. Planes are reprogrammed only
// between phases, once every result is back. A directed opening covers
// ties, negative extents, field extremes and an empty enable mask; random
// phases then sweep raw, tilted and axis-aligned plane sets under three
// handshake idling patterns.
// ----------------------------------------------------------------------------
module tb_top
    import fbsc_pkg::*;
();

    localparam int     CULL_PLANES = 6;
    localparam int     STALL_LIMIT = 5000;
    localparam int     SETTLE      = 2 * CULL_PLANES + 3;
    localparam longint Q14_ONE     = longint'(1) << Q14_SHIFT;

    localparam logic   MODE_BOX    = 1'b0;
    localparam logic   MODE_SPHERE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    localparam int PLANE_RAW    = 0;
    localparam int PLANE_TILTED = 1;
    localparam int PLANE_AXIS   = 2;

    typedef struct packed {
        logic               mode;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] size_x;
        logic signed [15:0] size_y;
        logic signed [15:0] size_z;
        logic [14:0]        radius;
    } obj_beat_t;

    typedef struct packed {
        logic visible;
        logic fully_inside;
    } verdict_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;

    fbsc_obj_if obj_ch ();
    fbsc_res_if res_ch ();

    frustum_box_sphere_cull_unit #(
        .NUM_PLANES (CULL_PLANES)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .obj         (obj_ch),
        .result      (res_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data)
    );

    logic [63:0] plane_regs [PLANE_REGS];
    logic [5:0]  plane_en;

    obj_beat_t   object_q [$];
    verdict_t    verdict_q [$];

    logic        beat_taken;
    int          src_idle_pct;
    int          snk_idle_pct;
    int          objects_sent;
    int          verdicts_seen;
    int          mismatches;
    int          stall_cycles;

    always #5 clk = ~clk;

    function automatic longint mag(input longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic verdict_t cull_verdict(input obj_beat_t o);
        longint   nx;
        longint   ny;
        longint   nz;
        longint   off;
        longint   d;
        longint   bound;
        longint   r;
        verdict_t v;
        v.visible      = 1'b1;
        v.fully_inside = 1'b1;
        r = longint'(o.radius) * Q14_ONE;
        for (int i = 0; i < CULL_PLANES && i < PLANE_REGS; i++)
        begin
            if (plane_en[i])
            begin
                nx  = longint'($signed(plane_regs[i][15:0]));
                ny  = longint'($signed(plane_regs[i][31:16]));
                nz  = longint'($signed(plane_regs[i][47:32]));
                off = longint'($signed(plane_regs[i][63:48])) * Q14_ONE;
                if (o.mode == MODE_BOX)
                begin
                    d = (2 * longint'(o.pos_x) + longint'(o.size_x)) * nx
                      + (2 * longint'(o.pos_y) + longint'(o.size_y)) * ny
                      + (2 * longint'(o.pos_z) + longint'(o.size_z)) * nz
                      - 2 * off;
                    bound = mag(longint'(o.size_x)) * mag(nx)
                          + mag(longint'(o.size_y)) * mag(ny)
                          + mag(longint'(o.size_z)) * mag(nz);
                    if (d > bound)
                        v.visible = 1'b0;
                end
                else
                begin
                    d = longint'(o.pos_x) * nx + longint'(o.pos_y) * ny
                      + longint'(o.pos_z) * nz - off;
                    if (d > r)
                        v.visible = 1'b0;
                    if (d > -r)
                        v.fully_inside = 1'b0;
                end
            end
        end
        v.fully_inside = v.fully_inside && v.visible && (o.mode == MODE_SPHERE);
        return v;
    endfunction

    function automatic logic [63:0] plane_word(
        input logic signed [15:0] nx,
        input logic signed [15:0] ny,
        input logic signed [15:0] nz,
        input logic signed [15:0] off
    );
        return {off, nz, ny, nx};
    endfunction

    function automatic obj_beat_t sphere_obj(
        input logic signed [15:0] px,
        input logic signed [15:0] py,
        input logic signed [15:0] pz,
        input logic [14:0]        r
    );
        obj_beat_t o;
        o        = '0;
        o.mode   = MODE_SPHERE;
        o.pos_x  = px;
        o.pos_y  = py;
        o.pos_z  = pz;
        o.radius = r;
        return o;
    endfunction

    function automatic obj_beat_t box_obj(
        input logic signed [15:0] px,
        input logic signed [15:0] py,
        input logic signed [15:0] pz,
        input logic signed [15:0] sx,
        input logic signed [15:0] sy,
        input logic signed [15:0] sz
    );
        obj_beat_t o;
        o        = '0;
        o.mode   = MODE_BOX;
        o.pos_x  = px;
        o.pos_y  = py;
        o.pos_z  = pz;
        o.size_x = sx;
        o.size_y = sy;
        o.size_z = sz;
        return o;
    endfunction

    function automatic logic signed [15:0] rand_coord(input int span);
        if (span >= 32768)
            return 16'($urandom());
        return 16'(int'($urandom_range(2 * span)) - span);
    endfunction

    function automatic obj_beat_t random_object(input int span);
        obj_beat_t o;
        o.mode   = 1'($urandom_range(1));
        o.pos_x  = rand_coord(span);
        o.pos_y  = rand_coord(span);
        o.pos_z  = rand_coord(span);
        o.size_x = rand_coord(span);
        o.size_y = rand_coord(span);
        o.size_z = rand_coord(span);
        o.radius = (span >= 32768) ? 15'($urandom()) : 15'($urandom_range(span));
        return o;
    endfunction

    function automatic logic [63:0] random_plane(input int style);
        logic signed [15:0] n [3];
        int                 axis;
        if (style == PLANE_RAW)
            return {$urandom(), $urandom()};
        if (style == PLANE_TILTED)
            return plane_word(rand_coord(16384), rand_coord(16384),
                              rand_coord(16384), rand_coord(2048));
        n[0] = '0;
        n[1] = '0;
        n[2] = '0;
        axis = $urandom_range(2);
        n[axis] = $urandom_range(1) ? 16'sd16384 : -16'sd16384;
        return plane_word(n[0], n[1], n[2], rand_coord(64));
    endfunction

    task automatic log_mismatch(input string what);
        if (mismatches < 10)
            $display("%0t mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic send(input obj_beat_t o);
        object_q.insert(object_q.size(), o);
        objects_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        if (idx < PLANE_REGS)
            plane_regs[idx] = val;
        else if (idx == REG_ENABLE)
            plane_en = val[5:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic drain();
        while (verdicts_seen != objects_sent)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic run_phase(
        input int         style,
        input logic [5:0] enables,
        input int         src_pct,
        input int         snk_pct,
        input int         count
    );
        int span;
        drain();
        for (int i = 0; i < PLANE_REGS; i++)
            write_reg(cfg_reg_t'(i), random_plane(style));
        write_reg(REG_ENABLE, 64'(enables));
        span = (style == PLANE_RAW) ? 32768 : (style == PLANE_TILTED) ? 2048 : 128;
        @(posedge clk);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        for (int k = 0; k < count; k++)
            send(random_object($urandom_range(99) < 20 ? 32768 : span));
    endtask

    // driver: hold a beat until taken, then advance or idle
    always @(negedge clk)
    begin : obj_driver
        obj_beat_t nxt;
        if (rst_n)
        begin
            if (!obj_ch.valid || beat_taken)
            begin
                if (object_q.size() != 0 && $urandom_range(99) >= src_idle_pct)
                begin
                    nxt = object_q.pop_front();
                    obj_ch.valid  <= 1'b1;
                    obj_ch.mode   <= nxt.mode;
                    obj_ch.pos_x  <= nxt.pos_x;
                    obj_ch.pos_y  <= nxt.pos_y;
                    obj_ch.pos_z  <= nxt.pos_z;
                    obj_ch.size_x <= nxt.size_x;
                    obj_ch.size_y <= nxt.size_y;
                    obj_ch.size_z <= nxt.size_z;
                    obj_ch.radius <= nxt.radius;
                end
                else
                    obj_ch.valid <= 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin : verdict_monitor
        obj_beat_t seen;
        verdict_t  want;
        if (rst_n)
        begin
            beat_taken <= obj_ch.valid && obj_ch.ready;
            if (obj_ch.valid && obj_ch.ready)
            begin
                seen.mode   = obj_ch.mode;
                seen.pos_x  = obj_ch.pos_x;
                seen.pos_y  = obj_ch.pos_y;
                seen.pos_z  = obj_ch.pos_z;
                seen.size_x = obj_ch.size_x;
                seen.size_y = obj_ch.size_y;
                seen.size_z = obj_ch.size_z;
                seen.radius = obj_ch.radius;
                verdict_q.insert(verdict_q.size(), cull_verdict(seen));
            end
            if (res_ch.valid && res_ch.ready)
            begin
                verdicts_seen++;
                if (verdict_q.size() == 0)
                    log_mismatch($sformatf("unexpected result visible %0b fully_inside %0b",
                                           res_ch.visible, res_ch.fully_inside));
                else
                begin
                    want = verdict_q.pop_front();
                    if (res_ch.visible !== want.visible
                        || res_ch.fully_inside !== want.fully_inside)
                        log_mismatch($sformatf(
                            "visible exp %0b got %0b, fully_inside exp %0b got %0b",
                            want.visible, res_ch.visible,
                            want.fully_inside, res_ch.fully_inside));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((obj_ch.valid && obj_ch.ready) || (res_ch.valid && res_ch.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("frustum_box_sphere_cull_unit regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wr_data   = '0;
        obj_ch.valid  = 1'b0;
        obj_ch.mode   = MODE_BOX;
        obj_ch.pos_x  = '0;
        obj_ch.pos_y  = '0;
        obj_ch.pos_z  = '0;
        obj_ch.size_x = '0;
        obj_ch.size_y = '0;
        obj_ch.size_z = '0;
        obj_ch.radius = '0;
        res_ch.ready  = 1'b0;
        beat_taken    = 1'b0;
        src_idle_pct  = 20;
        snk_idle_pct  = 84;
        objects_sent  = 0;
        verdicts_seen = 0;
        mismatches    = 0;
        stall_cycles  = 0;
        for (int i = 0; i < PLANE_REGS; i++)
            plane_regs[i] = '0;
        plane_en = 6'h3f;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // planes cleared after reset, all enabled
        @(posedge clk);
        send(sphere_obj(16'sd0, 16'sd0, 16'sd0, 15'd0));
        send(sphere_obj(-16'sd32768, 16'sd32767, -16'sd32768, 15'd32767));
        send(box_obj(16'sd32767, -16'sd32768, 16'sd32767,
                     -16'sd32768, 16'sd32767, -16'sd32768));
        drain();

        // single +x plane through the origin: ties on both bounds
        write_reg(REG_TOP, plane_word(16'sd16384, 16'sd0, 16'sd0, 16'sd0));
        write_reg(REG_ENABLE, 64'h1);
        write_reg(REG_SPARE, 64'h0);
        @(posedge clk);
        send(sphere_obj(16'sd80, 16'sd5, -16'sd9, 15'd80));
        send(sphere_obj(16'sd81, 16'sd0, 16'sd0, 15'd80));
        send(sphere_obj(-16'sd80, 16'sd0, 16'sd0, 15'd80));
        send(sphere_obj(-16'sd79, 16'sd0, 16'sd0, 15'd80));
        send(box_obj(16'sd0, 16'sd3, 16'sd0, 16'sd32, 16'sd7, 16'sd0));
        send(box_obj(16'sd1, 16'sd0, 16'sd0, 16'sd32, 16'sd0, 16'sd0));
        send(box_obj(16'sd32, 16'sd0, 16'sd0, -16'sd32, 16'sd0, 16'sd0));
        send(box_obj(16'sd33, 16'sd0, 16'sd0, -16'sd32, 16'sd0, 16'sd0));
        drain();

        // extreme plane words
        for (int i = 0; i < PLANE_REGS; i++)
            write_reg(cfg_reg_t'(i), (i % 2) ? 64'h7fff_7fff_7fff_7fff
                                             : 64'h8000_8000_8000_8000);
        write_reg(REG_ENABLE, 64'h3f);
        @(posedge clk);
        send(box_obj(16'sd32767, 16'sd32767, 16'sd32767,
                     16'sd32767, 16'sd32767, 16'sd32767));
        send(box_obj(-16'sd32768, -16'sd32768, -16'sd32768,
                     -16'sd32768, -16'sd32768, -16'sd32768));
        send(sphere_obj(-16'sd32768, -16'sd32768, -16'sd32768, 15'd32767));
        send(sphere_obj(16'sd32767, 16'sd32767, 16'sd32767, 15'd0));
        drain();

        // no plane enabled
        write_reg(REG_ENABLE, 64'h0);
        @(posedge clk);
        send(box_obj(16'sd32767, -16'sd32768, 16'sd100,
                     16'sd5, -16'sd32768, 16'sd32767));
        send(sphere_obj(16'sd32767, -16'sd32768, 16'sd0, 15'd0));
        send(sphere_obj(16'sd12, 16'sd34, -16'sd56, 15'd32767));

        run_phase(PLANE_TILTED, 6'h3f, 20, 84, 135);
        run_phase(PLANE_RAW, 6'($urandom()), 20, 84, 135);
        run_phase(PLANE_AXIS, 6'h3f, 84, 20, 135);
        run_phase(PLANE_TILTED, 6'($urandom()), 84, 20, 135);
        run_phase(PLANE_AXIS, 6'($urandom()), 0, 0, 135);
        run_phase(PLANE_RAW, 6'h3f, 0, 0, 135);
        drain();

        if (mismatches == 0 && verdict_q.size() == 0)
            $display("frustum_box_sphere_cull_unit regression: pass");
        else
            $display("frustum_box_sphere_cull_unit regression: fail");
        $finish;
    end

endmodule

/* filelist.f */
hdl/fbsc_pkg.sv
hdl/fbsc_obj_if.sv
hdl/fbsc_res_if.sv
hdl/fbsc_cell.sv
hdl/frustum_box_sphere_cull_unit.sv
hdl/fbsc_checker.sv
sim/tb_top.sv
